/* hdl/putk_pkg.sv */
// Shared types and constants for the per-user top-k rating keeper.
package putk_pkg;

   localparam int USER_W  = 12;
   localparam int ITEM_W  = 32;
   localparam int SCORE_W = 8;
   localparam int SLOT_W  = 3;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 48;

   // controller states
   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EVAL  = 2'd2;

   typedef struct packed {
      logic clear_wr;   // write a zero row at the sweep pointer
      logic accept;     // take a request word and read its row
      logic commit;     // decide, write back and load the result word
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last; // sweep pointer sits on the last row
      logic out_free;   // result register can take a word this cycle
   } dp_status_type;

endpackage

/* hdl/putk_ctrl.sv */
// Controller state machine: clearing sweep, request accept and evaluate.
module putk_ctrl
   import putk_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready   = (state_ff == ST_IDLE);
   assign cmd.clear_wr = (state_ff == ST_CLEAR);
   assign cmd.accept   = (state_ff == ST_IDLE) && req_tvalid;
   assign cmd.commit   = (state_ff == ST_EVAL) && status.out_free;

endmodule

/* hdl/putk_datapath.sv */
// Datapath: slot row memory, slot selection, write-back and result register.
module putk_datapath
   import putk_pkg::*;
#(
   parameter int SLOTS_PER_USER = 8,
   parameter int USER_COUNT     = 4096
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   input  logic [USER_W-1:0]     in_user_index,
   input  logic [ITEM_W-1:0]     in_item_id,
   input  logic [SCORE_W-1:0]    in_score,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic                  out_stored,
   output logic [SLOT_W-1:0]     out_slot_used,
   output logic [ITEM_W-1:0]     out_evicted_item,
   output logic [SCORE_W-1:0]    out_evicted_score
);

   localparam int ROW_AW   = (USER_COUNT > 1) ? $clog2(USER_COUNT) : 1;
   localparam int SW       = (SLOTS_PER_USER > 1) ? $clog2(SLOTS_PER_USER) : 1;
   localparam int TREE_P   = 1 << $clog2(SLOTS_PER_USER);
   localparam int NODES    = 2 * TREE_P - 1;
   localparam int ENTRY_W  = ITEM_W + SCORE_W;
   localparam int ROW_W    = SLOTS_PER_USER * ENTRY_W;

   // one row per user: slot s holds {score, id} at bits [s*ENTRY_W +: ENTRY_W]
   logic [ROW_W-1:0] mem [USER_COUNT];

   logic [ROW_AW-1:0]  clr_cnt_ff;
   logic [ROW_W-1:0]   rd_row_ff;
   logic [ROW_AW-1:0]  addr_ff;
   logic               ok_ff;
   logic [ITEM_W-1:0]  item_ff;
   logic [SCORE_W-1:0] score_ff;

   logic [ROW_AW+USER_W-1:0] user_ext;
   logic [ROW_AW-1:0]        rd_addr;
   logic                     in_ok;

   assign user_ext = {{ROW_AW{1'b0}}, in_user_index};
   assign rd_addr  = user_ext[ROW_AW-1:0];
   assign in_ok    = (32'(in_user_index) < 32'(USER_COUNT)) && (in_item_id != '0);

   // clearing sweep pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear_wr) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end
   assign status.clear_last = (clr_cnt_ff == ROW_AW'(USER_COUNT - 1));

   // request capture and row read
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rd_row_ff <= mem[rd_addr];
         addr_ff   <= rd_addr;
         ok_ff     <= in_ok;
         item_ff   <= in_item_id;
         score_ff  <= in_score;
      end
   end

   // slot selection
   logic [ITEM_W-1:0]  ids    [SLOTS_PER_USER];
   logic [SCORE_W-1:0] scores [SLOTS_PER_USER];
   logic               found;
   logic [SW-1:0]      empty_idx;
   logic [SCORE_W-1:0] node_val [NODES];
   logic [SW-1:0]      node_idx [NODES];
   logic [SW-1:0]      min_idx;
   logic [SCORE_W-1:0] min_val;
   logic               take;
   logic [SW-1:0]      target;
   logic [SW+SLOT_W-1:0] target_ext;
   logic [ROW_W-1:0]   new_row;

   always_comb begin
      found     = 1'b0;
      empty_idx = '0;
      for (int i = 0; i < SLOTS_PER_USER; i++) begin
         ids[i]    = rd_row_ff[i*ENTRY_W +: ITEM_W];
         scores[i] = rd_row_ff[i*ENTRY_W+ITEM_W +: SCORE_W];
      end
      // lowest empty slot wins
      for (int i = SLOTS_PER_USER - 1; i >= 0; i--) begin
         if (ids[i] == '0) begin
            found     = 1'b1;
            empty_idx = SW'(i);
         end
      end
      // min tree; the left child wins ties, pad leaves never beat a real slot
      for (int i = 0; i < TREE_P; i++) begin
         node_val[TREE_P-1+i] = (i < SLOTS_PER_USER) ? scores[i] : {SCORE_W{1'b1}};
         node_idx[TREE_P-1+i] = SW'(i);
      end
      for (int n = TREE_P - 2; n >= 0; n--) begin
         if (node_val[2*n+2] < node_val[2*n+1]) begin
            node_val[n] = node_val[2*n+2];
            node_idx[n] = node_idx[2*n+2];
         end else begin
            node_val[n] = node_val[2*n+1];
            node_idx[n] = node_idx[2*n+1];
         end
      end
      min_val = node_val[0];
      min_idx = node_idx[0];
   end

   assign take       = ok_ff && (found || (score_ff > min_val));
   assign target     = found ? empty_idx : min_idx;
   assign target_ext = {{SLOT_W{1'b0}}, target};

   always_comb begin
      new_row = rd_row_ff;
      for (int i = 0; i < SLOTS_PER_USER; i++) begin
         if (SW'(i) == target) begin
            new_row[i*ENTRY_W +: ENTRY_W] = {score_ff, item_ff};
         end
      end
   end

   // single write port: clearing sweep or write-back
   always_ff @(posedge clock) begin
      if (cmd.clear_wr) begin
         mem[clr_cnt_ff] <= '0;
      end else if (cmd.commit && take) begin
         mem[addr_ff] <= new_row;
      end
   end

   // result register
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_stored        <= take;
         out_slot_used     <= take ? target_ext[SLOT_W-1:0] : '0;
         out_evicted_item  <= (take && !found) ? ids[min_idx] : '0;
         out_evicted_score <= (take && !found) ? scores[min_idx] : '0;
      end
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign status.out_free = !rsp_valid_ff || rsp_tready;

endmodule

/* hdl/per_user_top_k_rating_keeper_top.sv */
// Timing: the accepting edge reads the user's row; the commit edge, taken once the
//   result register is free, writes any change back and raises rsp_tvalid.
// Throughput: one request word at a time; req_tready stays low from the accept through
//   the select and write-back on the single write port; a stalled result holds it.
// Reset: synchronous; afterwards a clearing sweep writes one row per cycle,
//   with req_tready low until it finishes.
module per_user_top_k_rating_keeper_top
   import putk_pkg::*;
#(
   parameter int SLOTS_PER_USER = 8,
   parameter int USER_COUNT     = 4096
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [11:0] user_index, [43:12] item_id, [51:44] score, [55:52] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] stored, [3:1] slot_used, [35:4] evicted_item, [43:36] evicted_score,
   // [47:44] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   // A request word is taken while an earlier result word still waits on rsp_tready.

   dp_cmd_type    cmd;
   dp_status_type status;

   logic               out_stored;
   logic [SLOT_W-1:0]  out_slot_used;
   logic [ITEM_W-1:0]  out_evicted_item;
   logic [SCORE_W-1:0] out_evicted_score;

   // sequence the sweep, accept and commit steps
   putk_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // hold the slot rows, pick the slot and drive the result word
   putk_datapath #(
      .SLOTS_PER_USER (SLOTS_PER_USER),
      .USER_COUNT     (USER_COUNT)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .in_user_index     (req_tdata[11:0]),
      .in_item_id        (req_tdata[43:12]),
      .in_score          (req_tdata[51:44]),
      .rsp_tready        (rsp_tready),
      .rsp_tvalid        (rsp_tvalid),
      .out_stored        (out_stored),
      .out_slot_used     (out_slot_used),
      .out_evicted_item  (out_evicted_item),
      .out_evicted_score (out_evicted_score)
   );

   // pack the result word, lowest field first
   assign rsp_tdata = {4'b0000, out_evicted_score, out_evicted_item, out_slot_used,
                       out_stored};

endmodule

/* dv/per_user_top_k_rating_keeper_top_test.sv */
// Self-checking testbench for the per-user top-k rating keeper.
module per_user_top_k_rating_keeper_top_test
   import putk_pkg::*;
();

   localparam int SLOTS_PER_USER = 8;
   localparam int USER_COUNT     = 4096;
   localparam int SLOT_DEPTH     = SLOTS_PER_USER * USER_COUNT;
   localparam int HOT_USERS      = 16;
   localparam int REQ_PAD_W      = REQ_DATA_W - USER_W - ITEM_W - SCORE_W;

   // one result word, unpacked into its fields
   typedef struct packed {
      logic                stored;
      logic [SLOT_W-1:0]   slot_used;
      logic [ITEM_W-1:0]   evicted_item;
      logic [SCORE_W-1:0]  evicted_score;
   } rating_result_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // shadow copy of every user's slot row
   bit [ITEM_W-1:0]  kept_items  [SLOT_DEPTH];
   bit [SCORE_W-1:0] kept_scores [SLOT_DEPTH];

   rating_result_type pending_results[$];
   int                fail_count = 0;
   bit                idle_on    = 1'b1;

   per_user_top_k_rating_keeper_top #(
      .SLOTS_PER_USER (SLOTS_PER_USER),
      .USER_COUNT     (USER_COUNT)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop, far beyond the slowest legal run (clearing sweep plus
   // about 1200 words, each with the longest gap and stall).
   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // Apply one insert to the shadow rows and return the result word it
   // must produce: fill the lowest empty slot, else replace the
   // lowest-numbered minimum only on a strictly greater rating.
   function automatic rating_result_type predict_insert(input logic [USER_W-1:0]  user,
                                                        input logic [ITEM_W-1:0]  item,
                                                        input logic [SCORE_W-1:0] score);
      rating_result_type res;
      int                base;
      int                target;
      int                low;
      bit                take;
      res    = '0;
      target = 0;
      take   = 1'b0;
      // drop a user past the table and an id that would read as empty
      if (int'(user) >= USER_COUNT || item == '0)
         return res;
      base = int'(user) * SLOTS_PER_USER;
      for (int s = 0; s < SLOTS_PER_USER && !take; s++) begin
         if (kept_items[base + s] == '0) begin
            target = s;
            take   = 1'b1;
         end
      end
      if (!take) begin
         low = 0;
         for (int s = 1; s < SLOTS_PER_USER; s++) begin
            if (kept_scores[base + s] < kept_scores[base + low])
               low = s;
         end
         if (score > kept_scores[base + low]) begin
            target            = low;
            take              = 1'b1;
            res.evicted_item  = kept_items[base + low];
            res.evicted_score = kept_scores[base + low];
         end
      end
      if (take) begin
         kept_items[base + target]  = item;
         kept_scores[base + target] = score;
         res.stored                 = 1'b1;
         res.slot_used              = target[SLOT_W-1:0];
      end
      return res;
   endfunction

   // Drive one insert word at the falling edge, hold it until accepted,
   // and queue its prediction at the accepting edge. Leave tvalid high so
   // that back-to-back words never see a low-high pair in one step.
   task automatic send_insert(input logic [USER_W-1:0]  user,
                              input logic [ITEM_W-1:0]  item,
                              input logic [SCORE_W-1:0] score);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 19);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{REQ_PAD_W{1'b0}}, score, item, user};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(predict_insert(user, item, score));
      @(negedge clock);
   endtask

   // Drop tvalid and hold until every queued result word has come back,
   // then let the pipeline settle.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic report_field(input string name, input logic [ITEM_W-1:0] want,
                               input logic [ITEM_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   task automatic check_rating_word(input logic [RSP_DATA_W-1:0] word);
      rating_result_type want;
      rating_result_type got;
      got.stored        = word[0];
      got.slot_used     = word[SLOT_W:1];
      got.evicted_item  = word[SLOT_W+ITEM_W:SLOT_W+1];
      got.evicted_score = word[SLOT_W+ITEM_W+SCORE_W:SLOT_W+ITEM_W+1];
      if (pending_results.size() == 0) begin
         $display("%0t: result word with none expected, expected nothing, actual %h",
                  $time, word);
         fail_count++;
         return;
      end
      want = pending_results.pop_front();
      report_field("stored", ITEM_W'(want.stored), ITEM_W'(got.stored));
      report_field("slot_used", ITEM_W'(want.slot_used), ITEM_W'(got.slot_used));
      report_field("evicted_item", want.evicted_item, got.evicted_item);
      report_field("evicted_score", ITEM_W'(want.evicted_score),
                   ITEM_W'(got.evicted_score));
   endtask

   // Sample the result channel at the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         check_rating_word(rsp_tdata);
   end

   // Result-side back-pressure: random stall bursts separated by stretches
   // of steady ready; none once idle_on is cleared.
   initial begin
      forever begin
         @(negedge clock);
         if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clock);
            rsp_tready <= 1'b1;
            repeat ($urandom_range(0, 30)) @(negedge clock);
         end
      end
   end

   // Fill all eight slots of user 0; slots 2 and 3 tie for the minimum.
   task automatic test_fill_empty_slots();
      send_insert(12'd0, 32'h0000_0001, 8'h10);
      send_insert(12'd0, 32'hFFFF_FFFF, 8'h20);
      send_insert(12'd0, 32'h8000_0000, 8'h05);
      send_insert(12'd0, 32'h0000_0003, 8'h05);
      send_insert(12'd0, 32'hA5A5_A5A5, 8'hFF);
      send_insert(12'd0, 32'h5A5A_5A5A, 8'h30);
      send_insert(12'd0, 32'h1234_5678, 8'h40);
      send_insert(12'd0, 32'h7FFF_FFFF, 8'h5A);
   endtask

   // Full row: lower, equal and zero ratings are all turned away.
   task automatic test_keep_on_low_score();
      send_insert(12'd0, 32'h0000_0200, 8'h04);
      send_insert(12'd0, 32'h0000_0201, 8'h05);
      send_insert(12'd0, 32'h0000_0202, 8'h00);
   endtask

   // Replace the lowest-numbered minimum, then its tied twin, then refuse
   // an equal rating, then replace again on a strictly greater one.
   task automatic test_replace_minimum();
      send_insert(12'd0, 32'h0000_0100, 8'h06);
      send_insert(12'd0, 32'h0000_0101, 8'h06);
      send_insert(12'd0, 32'h0000_0102, 8'h06);
      send_insert(12'd0, 32'h0000_0103, 8'h07);
   endtask

   // An id of zero is dropped, whether the row has room or not.
   task automatic test_zero_item_id();
      send_insert(12'd1, 32'h0000_0000, 8'h80);
      send_insert(12'd0, 32'h0000_0000, 8'hFF);
   endtask

   // Top user index with all-zero ratings: zero is refused, one replaces
   // slot 0.
   task automatic test_top_user();
      for (int s = 0; s < SLOTS_PER_USER; s++)
         send_insert(12'hFFF, 32'h0000_1000 + s, 8'h00);
      send_insert(12'hFFF, 32'h0000_2000, 8'h00);
      send_insert(12'hFFF, 32'hFFFF_FFFE, 8'h01);
   endtask

   // Mostly inserts to a small pool of users so that rows fill and
   // replacement dominates; repeats of the same user exercise the
   // interlock, and narrow ratings make ties common.
   task automatic test_random_inserts(input int count);
      int                 hot [HOT_USERS];
      int                 pick;
      logic [USER_W-1:0]  user;
      logic [ITEM_W-1:0]  item;
      logic [SCORE_W-1:0] score;
      foreach (hot[i]) hot[i] = $urandom_range(0, USER_COUNT - 1);
      user = USER_W'(hot[0]);
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick >= 20) begin
            if (pick < 85)
               user = USER_W'(hot[$urandom_range(0, HOT_USERS - 1)]);
            else
               user = USER_W'($urandom_range(0, USER_COUNT - 1));
         end
         item = $urandom();
         if ($urandom_range(0, 19) == 0)
            item = '0;
         else if (item == '0)
            item = 32'd1;
         if ($urandom_range(0, 1) == 0)
            score = SCORE_W'($urandom_range(0, 15));
         else
            score = SCORE_W'($urandom_range(0, 255));
         send_insert(user, item, score);
      end
   endtask

   // Sender holds off until the block has returned every result word.
   task automatic test_pause_until_drained();
      wait_for_results();
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      test_fill_empty_slots();
      test_keep_on_low_score();
      test_replace_minimum();
      test_zero_item_id();
      test_top_user();
      test_random_inserts(450);
      test_pause_until_drained();
      test_random_inserts(450);
      // last stretch: full rate on both sides
      idle_on = 1'b0;
      test_random_inserts(250);
      wait_for_results();
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

/* files.f */
hdl/putk_pkg.sv
hdl/putk_ctrl.sv
hdl/putk_datapath.sv
hdl/per_user_top_k_rating_keeper_top.sv
dv/per_user_top_k_rating_keeper_top_test.sv
